>>> hw/rtl/sfws_pkg.sv
// ----------------------------------------------------------------------------
// sfws_pkg
// Constants, tables and types shared by the frequency word search block.
// ----------------------------------------------------------------------------
`default_nettype none
package sfws_pkg;

    localparam int unsigned NUM_REFS = 9;
    localparam int unsigned RECIP_SHIFT = 44;

    localparam logic [30:0] IF_HZ     = 31'd150000;
    localparam logic [24:0] WORD_MIN  = 25'd4194304;
    localparam logic [24:0] WORD_MAX  = 25'd16751615;
    localparam logic [24:0] HALF_STEP = 25'd8192;
    localparam logic [31:0] BAND_LOW_LIMIT = 32'd400000000;
    localparam logic [31:0] BAND_MID_LIMIT = 32'd500000000;
    localparam logic [3:0]  DIV_OFFSET = 4'd6;

    localparam logic [1:0] BAND_LOW  = 2'd0;
    localparam logic [1:0] BAND_MID  = 2'd1;
    localparam logic [1:0] BAND_HIGH = 2'd2;

    localparam logic [21:0] FREF_TAB [NUM_REFS] = '{
        22'd2457600, 22'd2106514, 22'd1843200, 22'd1638400, 22'd1474560,
        22'd1340509, 22'd1228800, 22'd1134277, 22'd1053257
    };

    // floor(2^46 / fref): estimate of 4*s/fref after a shift of 44
    localparam logic [26:0] RECIP_TAB [NUM_REFS] = '{
        27'((64'd1 << 46) / 64'd2457600), 27'((64'd1 << 46) / 64'd2106514),
        27'((64'd1 << 46) / 64'd1843200), 27'((64'd1 << 46) / 64'd1638400),
        27'((64'd1 << 46) / 64'd1474560), 27'((64'd1 << 46) / 64'd1340509),
        27'((64'd1 << 46) / 64'd1228800), 27'((64'd1 << 46) / 64'd1134277),
        27'((64'd1 << 46) / 64'd1053257)
    };

    localparam logic [11:0] COR_TAB [NUM_REFS] = '{
        12'd1213, 12'd1416, 12'd1618, 12'd1820, 12'd2022,
        12'd2224, 12'd2427, 12'd2629, 12'd2831
    };

    localparam logic [9:0] SEP_TAB [NUM_REFS] = '{
        10'h1AA, 10'h1F1, 10'h238, 10'h280, 10'h2C7,
        10'h30E, 10'h355, 10'h39C, 10'h3E3
    };

    typedef struct packed {
        logic        ok;
        logic [30:0] err;
        logic [31:0] chan;
        logic [23:0] rx;
        logic [23:0] tx;
    } t_cand;

    typedef struct packed {
        logic        found;
        logic [30:0] err;
        logic [31:0] chan;
        logic [23:0] rx;
        logic [23:0] tx;
        logic [3:0]  idx;
    } t_best;

endpackage
`default_nettype wire

>>> hw/rtl/sfws_if.sv
// ----------------------------------------------------------------------------
// sfws request and result channels
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface sfws_req_if;
    logic        valid;
    logic        ready;
    logic [29:0] desired_hz;
    modport source (output valid, output desired_hz, input ready);
    modport sink (input valid, input desired_hz, output ready);
endinterface

interface sfws_res_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] actual_hz;
    logic [23:0] rx_word;
    logic [23:0] tx_word;
    logic [9:0]  sep_word;
    logic [3:0]  ref_divider;
    logic [30:0] error_hz;
    logic [1:0]  band;
    modport source (output valid, output found, output actual_hz, output rx_word,
                    output tx_word, output sep_word, output ref_divider,
                    output error_hz, output band, input ready);
    modport sink (input valid, input found, input actual_hz, input rx_word,
                  input tx_word, input sep_word, input ref_divider,
                  input error_hz, input band, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/sfws_lane.sv
// ----------------------------------------------------------------------------
// sfws_lane
// One reference candidate: quotient by reciprocal, rounding, words, error.
// ----------------------------------------------------------------------------
`default_nettype none
module sfws_lane (
    input  wire logic               i_clk,
    input  wire logic [3:0]         i_idx,
    input  wire logic [5:2]         i_en,
    input  wire logic [30:0]        i_s1,
    input  wire logic [30:0]        i_s2,
    input  wire logic [29:0]        i_want4,
    output sfws_pkg::t_cand         o_cand
);
    import sfws_pkg::*;

    logic [21:0] fref;
    logic [26:0] recip;
    logic [11:0] cor;
    logic [57:0] prod;
    logic [33:0] qf;
    logic [33:0] rem;
    logic [12:0] q;
    logic [12:0] qr;
    logic        half;
    logic [10:0] n;
    logic [24:0] rx;
    logic [24:0] tx;
    logic [32:0] raw;
    logic [32:0] chan;
    logic [32:0] want;

    logic [12:0] r_q0;
    logic [12:0] r_q;
    logic [24:0] r_rx4;
    logic [24:0] r_tx4;
    logic        r_ok4;
    logic [32:0] r_raw;
    t_cand       r_cand;

    assign fref  = FREF_TAB[i_idx];
    assign recip = RECIP_TAB[i_idx];
    assign cor   = COR_TAB[i_idx];

    always_comb begin
        prod = 58'(i_s1) * 58'(recip);
        qf   = 34'(r_q0) * 34'(fref);
        rem  = {1'b0, i_s2, 2'b00} - qf;
        q    = r_q0 + 13'(rem >= 34'(fref));
        qr   = r_q + 13'(r_q[0]);
        half = qr[1];
        n    = qr[12:2];
        rx   = {n, 14'b0} - (half ? 25'd0 : HALF_STEP);
        tx   = rx - 25'(cor);
        raw  = 33'(n) * 33'(fref) + (half ? 33'(fref[21:1]) : 33'd0);
        chan = r_raw - 33'(IF_HZ);
        want = 33'(i_want4);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_q0 <= prod[RECIP_SHIFT +: 13];
        end
        if (i_en[3]) begin
            r_q <= q;
        end
        if (i_en[4]) begin
            r_rx4 <= rx;
            r_tx4 <= tx;
            r_ok4 <= (rx >= WORD_MIN) && (rx <= WORD_MAX)
                  && (tx >= WORD_MIN) && (tx <= WORD_MAX);
            r_raw <= raw;
        end
        if (i_en[5]) begin
            r_cand.ok   <= r_ok4;
            r_cand.chan <= chan[31:0];
            r_cand.err  <= (chan >= want) ? 31'(chan - want) : 31'(want - chan);
            r_cand.rx   <= r_rx4[23:0];
            r_cand.tx   <= r_tx4[23:0];
        end
    end

    assign o_cand = r_cand;

endmodule
`default_nettype wire

>>> hw/rtl/sfws_select.sv
// ----------------------------------------------------------------------------
// sfws_select
// Two-level registered pick of the closest legal candidate, first on a tie.
// ----------------------------------------------------------------------------
`default_nettype none
module sfws_select (
    input  wire logic               i_clk,
    input  wire logic [7:6]         i_en,
    input  sfws_pkg::t_cand         i_cand [sfws_pkg::NUM_REFS],
    output sfws_pkg::t_best         o_best,
    output logic [1:0]              o_band
);
    import sfws_pkg::*;

    localparam int unsigned GROUPS = NUM_REFS / 3;

    t_best grp [GROUPS];
    t_best r_grp [GROUPS];
    t_best fin;
    t_best r_best;
    logic [1:0] band;
    logic [1:0] r_band;

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            grp[g] = '0;
            grp[g].err = 31'h7fffffff;
            for (int k = 0; k < 3; k++) begin
                if (i_cand[g * 3 + k].ok && (i_cand[g * 3 + k].err < grp[g].err)) begin
                    grp[g].found = 1'b1;
                    grp[g].err   = i_cand[g * 3 + k].err;
                    grp[g].chan  = i_cand[g * 3 + k].chan;
                    grp[g].rx    = i_cand[g * 3 + k].rx;
                    grp[g].tx    = i_cand[g * 3 + k].tx;
                    grp[g].idx   = 4'(g * 3 + k);
                end
            end
        end
        fin = r_grp[0];
        for (int g = 1; g < GROUPS; g++) begin
            if (r_grp[g].found && (!fin.found || (r_grp[g].err < fin.err))) begin
                fin = r_grp[g];
            end
        end
        if (!fin.found) begin
            fin = '0;
        end
        priority if (!fin.found) begin
            band = BAND_LOW;
        end else if (fin.chan < BAND_LOW_LIMIT) begin
            band = BAND_LOW;
        end else if (fin.chan < BAND_MID_LIMIT) begin
            band = BAND_MID;
        end else begin
            band = BAND_HIGH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_grp <= grp;
        end
        if (i_en[7]) begin
            r_best <= fin;
            r_band <= band;
        end
    end

    assign o_best = r_best;
    assign o_band = r_band;

endmodule
`default_nettype wire

>>> hw/rtl/synth_frequency_word_search.sv
// ----------------------------------------------------------------------------
// synth_frequency_word_search
// Picks the reference divider and synthesizer words closest to a request.
// ----------------------------------------------------------------------------
// Seven-stage pipeline taking one request item per clock unless held by
// back-pressure. The depth is set by the input sum with the IF offset, the
// reciprocal multiply, the remainder correction, the word and channel
// multiply, the error stage and a two-level selection over nine references.
// Each stage holds its item under output back-pressure while empty stages
// ahead keep filling, so requests are still taken while a result waits.
`default_nettype none
module synth_frequency_word_search (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sfws_req_if.sink   i_req,
    sfws_res_if.source o_res
);
    import sfws_pkg::*;

    localparam int unsigned DEPTH = 7;

    logic [DEPTH:1]   r_v;
    logic [DEPTH+1:1] en;
    logic [30:0]      r_s1;
    logic [30:0]      r_s2;
    logic [29:0]      r_w [4:1];
    t_cand            cand [NUM_REFS];
    t_best            best;
    logic [1:0]       band;

    always_comb begin
        en[DEPTH+1] = o_res.ready;
        for (int k = DEPTH; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_req.valid;
            end
            for (int k = 2; k <= DEPTH; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1    <= 31'(i_req.desired_hz) + IF_HZ;
            r_w[1]  <= i_req.desired_hz;
        end
        if (en[2]) begin
            r_s2   <= r_s1;
            r_w[2] <= r_w[1];
        end
        if (en[3]) begin
            r_w[3] <= r_w[2];
        end
        if (en[4]) begin
            r_w[4] <= r_w[3];
        end
    end

    for (genvar i = 0; i < NUM_REFS; i++) begin : g_lane
        sfws_lane u_lane (
            .i_clk   (i_clk),
            .i_idx   (4'(i)),
            .i_en    (en[5:2]),
            .i_s1    (r_s1),
            .i_s2    (r_s2),
            .i_want4 (r_w[4]),
            .o_cand  (cand[i])
        );
    end

    sfws_select u_select (
        .i_clk  (i_clk),
        .i_en   (en[7:6]),
        .i_cand (cand),
        .o_best (best),
        .o_band (band)
    );

    assign i_req.ready       = en[1];
    assign o_res.valid       = r_v[DEPTH];
    assign o_res.found       = best.found;
    assign o_res.actual_hz   = best.chan;
    assign o_res.rx_word     = best.rx;
    assign o_res.tx_word     = best.tx;
    assign o_res.sep_word    = best.found ? SEP_TAB[best.idx] : 10'd0;
    assign o_res.ref_divider = best.found ? best.idx + DIV_OFFSET : 4'd0;
    assign o_res.error_hz    = best.err;
    assign o_res.band        = band;

endmodule
`default_nettype wire

>>> tb/sv/tb_synth_frequency_word_search.sv
// ----------------------------------------------------------------------------
// tb_synth_frequency_word_search
// Drives tuning requests through the word search block and checks every
// result item against a local search over the nine reference frequencies.
// ----------------------------------------------------------------------------
module tb_synth_frequency_word_search;
    timeunit 1ns;
    timeprecision 1ps;
    import sfws_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned N_RANDOM = 900;
    localparam int unsigned N_DIRECTED = 14;

    typedef struct packed {
        logic        found;
        logic [31:0] actual_hz;
        logic [23:0] rx_word;
        logic [23:0] tx_word;
        logic [9:0]  sep_word;
        logic [3:0]  ref_divider;
        logic [30:0] error_hz;
        logic [1:0]  band;
    } t_tuning;

    typedef struct packed {
        logic [29:0] desired_hz;
        logic        typed;
        t_tuning     tuning;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sfws_req_if req_ch ();
    sfws_res_if res_ch ();

    synth_frequency_word_search u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_tuning     tuning_q[$];
    int unsigned n_fail = 0;
    int unsigned cycle_cnt = 0;
    int unsigned send_idle_pct = 28;
    int unsigned recv_idle_pct = 76;
    t_row        rows [N_DIRECTED];

    function automatic t_tuning search_words(logic [29:0] want);
        t_tuning     best;
        longint      best_err;
        longint      fref;
        longint      q;
        longint      n;
        longint      rx;
        longint      tx;
        longint      chan;
        longint      err;
        logic        half;
        best = '0;
        best_err = 64'h7fffffff;
        for (int i = 0; i < NUM_REFS; i++) begin
            fref = FREF_TAB[i];
            q = ((longint'(want) + 150000) * 4) / fref;
            if (q[0]) q++;
            half = q[1];
            n = q >>> 2;
            rx = n * 16384 - 8192 + (half ? 8192 : 0);
            if (rx < 4194304 || rx > 16751615) continue;
            tx = rx - COR_TAB[i];
            if (tx < 4194304 || tx > 16751615) continue;
            chan = n * fref + (half ? (fref >>> 1) : 0) - 150000;
            err = chan - longint'(want);
            if (err < 0) err = -err;
            if (err < best_err) begin
                best_err = err;
                best.found = 1'b1;
                best.actual_hz = chan[31:0];
                best.rx_word = rx[23:0];
                best.tx_word = tx[23:0];
                best.sep_word = SEP_TAB[i];
                best.ref_divider = 4'(i) + DIV_OFFSET;
                best.error_hz = err[30:0];
                best.band = (chan < 400000000) ? BAND_LOW :
                            (chan < 500000000) ? BAND_MID : BAND_HIGH;
            end
        end
        return best;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_fail++;
    endtask

    task automatic send_request(logic [29:0] hz);
        logic acc;
        while ($urandom_range(99, 0) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.desired_hz <= hz;
        do begin
            @(negedge i_clk);
            acc = req_ch.ready;
            @(posedge i_clk);
        end while (!acc);
        tuning_q.push_back(search_words(hz));
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
        if (i_rst_n) begin
            res_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (tuning_q.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                t_tuning w;
                w = tuning_q.pop_front();
                if (res_ch.found !== w.found)
                    report_mismatch("found", res_ch.found, w.found);
                if (res_ch.actual_hz !== w.actual_hz)
                    report_mismatch("actual_hz", res_ch.actual_hz, w.actual_hz);
                if (res_ch.rx_word !== w.rx_word)
                    report_mismatch("rx_word", res_ch.rx_word, w.rx_word);
                if (res_ch.tx_word !== w.tx_word)
                    report_mismatch("tx_word", res_ch.tx_word, w.tx_word);
                if (res_ch.sep_word !== w.sep_word)
                    report_mismatch("sep_word", res_ch.sep_word, w.sep_word);
                if (res_ch.ref_divider !== w.ref_divider)
                    report_mismatch("ref_divider", res_ch.ref_divider, w.ref_divider);
                if (res_ch.error_hz !== w.error_hz)
                    report_mismatch("error_hz", res_ch.error_hz, w.error_hz);
                if (res_ch.band !== w.band)
                    report_mismatch("band", res_ch.band, w.band);
            end
        end
    end

    function automatic logic [29:0] pick_request();
        int unsigned k;
        k = $urandom_range(9, 0);
        if (k < 6) return 30'($urandom_range(980000000, 100000000));
        if (k < 8) return 30'($urandom_range(120000000, 60000000));
        if (k == 8) return 30'($urandom_range(1073591823, 1000000000));
        return 30'($urandom);
    endfunction

    initial begin
        t_tuning     w;
        int unsigned phase;
        req_ch.valid = 1'b0;
        req_ch.desired_hz = '0;
        res_ch.ready = 1'b0;
        // requests with no legal word, top of the request range, band edges
        rows[0]  = '{30'd0, 1'b1, t_tuning'('0)};
        rows[1]  = '{30'd1, 1'b1, t_tuning'('0)};
        rows[2]  = '{30'h3fffffff, 1'b0, t_tuning'('0)};
        rows[3]  = '{30'd1073591823, 1'b0, t_tuning'('0)};
        rows[4]  = '{30'd433920000, 1'b0, t_tuning'('0)};
        rows[5]  = '{30'd399999999, 1'b0, t_tuning'('0)};
        rows[6]  = '{30'd400000000, 1'b0, t_tuning'('0)};
        rows[7]  = '{30'd499999999, 1'b0, t_tuning'('0)};
        rows[8]  = '{30'd500000000, 1'b0, t_tuning'('0)};
        rows[9]  = '{30'd914998000, 1'b0, t_tuning'('0)};
        rows[10] = '{30'd300000000, 1'b0, t_tuning'('0)};
        rows[11] = '{30'd629000000, 1'b0, t_tuning'('0)};
        rows[12] = '{30'd868000000, 1'b0, t_tuning'('0)};
        rows[13] = '{30'h2aaaaaaa, 1'b0, t_tuning'('0)};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int r = 0; r < N_DIRECTED; r++) begin
            send_request(rows[r].desired_hz);
            if (rows[r].typed) begin
                w = tuning_q.pop_back();
                tuning_q.push_back(rows[r].tuning);
                if (w !== rows[r].tuning)
                    report_mismatch("predictor row", r, r);
            end
        end
        req_ch.valid <= 1'b0;
        // hold off until the pipeline drains
        while (tuning_q.size() != 0) @(posedge i_clk);
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 76 : 0;
            recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 28 : 0;
            for (int k = 0; k < N_RANDOM / 3; k++) send_request(pick_request());
        end
        req_ch.valid <= 1'b0;
        while (tuning_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

>>> files.f
hw/rtl/sfws_pkg.sv
hw/rtl/sfws_if.sv
hw/rtl/sfws_lane.sv
hw/rtl/sfws_select.sv
hw/rtl/synth_frequency_word_search.sv
tb/sv/tb_synth_frequency_word_search.sv
